### sv/rle_scanline_decoder_macros.svh
// Assertion helpers for the scanline decoder.
`ifndef RLE_SCANLINE_DECODER_MACROS_SVH
`define RLE_SCANLINE_DECODER_MACROS_SVH

// Checked only outside reset.
`define RSD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define RSD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/rsd_pkg.sv
package rsd_pkg;

  localparam int unsigned COL_W       = 17;
  localparam int unsigned WIDTH_W     = 16;
  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [COL_W-1:0]   COL_MAX     = '1;
  localparam logic [WIDTH_W-1:0] WIDTH_RESET = WIDTH_W'(1);

  typedef enum logic [1:0] {
    KIND_RUN      = 2'd0,
    KIND_COMPLETE = 2'd1,
    KIND_MISMATCH = 2'd2,
    KIND_TRUNC    = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t            kind;
    logic [7:0]       value;
    logic [6:0]       len;
    logic [COL_W-1:0] col;
    logic             last;
  } record_t;

endpackage

### sv/rsd_stream_if.sv
interface rsd_code_if;
  logic       valid;
  logic       ready;
  logic [7:0] code_byte;
  logic       scanline_end;

  modport source (output valid, output code_byte, output scanline_end, input ready);
  modport sink   (input valid, input code_byte, input scanline_end, output ready);
endinterface

interface rsd_record_if
  import rsd_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [1:0]       record_kind;
  logic [7:0]       pixel_value;
  logic [6:0]       run_length;
  logic [COL_W-1:0] start_column;
  logic             last_of_run;

  modport source (output valid, output record_kind, output pixel_value, output run_length,
                  output start_column, output last_of_run, input ready);
  modport sink   (input valid, input record_kind, input pixel_value, input run_length,
                  input start_column, input last_of_run, output ready);
endinterface

### sv/rle_scanline_decoder.sv
// Run-length scanline decoder, 8-bit samples.
// codes (sink): one encoded byte per request, scanline_end set on the last byte of a line.
// records (source): pixel runs (literal bytes come out as runs of length 1) and one
//   status record per line (complete, width mismatch or truncated) carrying the final column.
// cfg_wr_en / cfg_wr_data: write scanline_width; only while the block is idle.
// A record enters the queue when the byte that causes it is accepted and is offered from there on records.
// Throughput: one byte per cycle while codes.ready is high. Records leave through a 4-entry
//   queue at one per cycle while the receiver is ready; codes.ready holds while at least two
//   entries are free, so a byte that yields a pixel record and a status record fits in the queue.
// When the receiver stalls, the queue fills and codes.ready drops until entries drain.
// Reset (rst, synchronous, active high) empties the queue, returns the parser to expect
//   an instruction byte at column 0 and sets scanline_width to 1.
`include "rle_scanline_decoder_macros.svh"

module rle_scanline_decoder
  import rsd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [WIDTH_W-1:0] cfg_wr_data,
  rsd_code_if.sink           codes,
  rsd_record_if.source       records
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(QUEUE_DEPTH);
  localparam logic [CNT_W-1:0] CNT_ROOM2 = CNT_W'(QUEUE_DEPTH - 2);

  typedef enum logic [3:0] {
    PH_INSTR  = 4'b0001,
    PH_RUNVAL = 4'b0010,
    PH_LIT    = 4'b0100,
    PH_STOP   = 4'b1000
  } phase_t;

  function automatic logic [COL_W-1:0] col_add(input logic [COL_W-1:0] c,
                                              input logic [6:0] n);
    logic [COL_W:0] s;
    s = {1'b0, c} + {{(COL_W-6){1'b0}}, n};
    return s[COL_W] ? COL_MAX : s[COL_W-1:0];
  endfunction

  logic [WIDTH_W-1:0] scanline_width;
  phase_t             phase, phase_step, phase_next;
  logic [6:0]         count_left, count_step, count_left_next;
  logic [COL_W-1:0]   column, col_step, column_next;

  record_t            queue [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [CNT_W-1:0]   count, count_next;

  logic               accept, pop;
  logic               pix_valid;
  logic [6:0]         pix_len;
  record_t            pix_rec, stat_rec;
  kind_t              stat_kind;
  logic [1:0]         push_n;

  assign accept = codes.valid && codes.ready;
  assign pop    = records.valid && records.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      scanline_width <= WIDTH_RESET;
    end else if (cfg_wr_en) begin
      scanline_width <= cfg_wr_data;
    end
  end

  // Parser step for the current byte.
  always_comb begin
    phase_step = phase;
    count_step = count_left;
    col_step   = column;
    pix_valid  = 1'b0;
    pix_len    = 7'd1;
    unique case (phase)
      PH_INSTR: begin
        if (codes.code_byte == 8'd0) begin
          phase_step = PH_STOP;
        end else begin
          count_step = codes.code_byte[6:0];
          if (!codes.code_byte[7]) begin
            phase_step = PH_RUNVAL;
          end else if (codes.code_byte[6:0] != 7'd0) begin
            phase_step = PH_LIT;
          end
        end
      end
      PH_RUNVAL: begin
        pix_valid  = 1'b1;
        pix_len    = count_left;
        col_step   = col_add(column, count_left);
        count_step = 7'd0;
        phase_step = PH_INSTR;
      end
      PH_LIT: begin
        pix_valid  = 1'b1;
        col_step   = col_add(column, 7'd1);
        count_step = count_left - 7'd1;
        if (count_left == 7'd1) begin
          phase_step = PH_INSTR;
        end
      end
      PH_STOP: begin
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    priority if (phase_step == PH_RUNVAL || phase_step == PH_LIT) begin
      stat_kind = KIND_TRUNC;
    end else if (col_step == {1'b0, scanline_width}) begin
      stat_kind = KIND_COMPLETE;
    end else begin
      stat_kind = KIND_MISMATCH;
    end
  end

  always_comb begin
    pix_rec.kind   = KIND_RUN;
    pix_rec.value  = codes.code_byte;
    pix_rec.len    = pix_len;
    pix_rec.col    = column;
    pix_rec.last   = !codes.scanline_end;
    stat_rec.kind  = stat_kind;
    stat_rec.value = 8'd0;
    stat_rec.len   = 7'd0;
    stat_rec.col   = col_step;
    stat_rec.last  = 1'b1;
  end

  always_comb begin
    phase_next      = phase;
    count_left_next = count_left;
    column_next     = column;
    if (accept) begin
      if (codes.scanline_end) begin
        phase_next      = PH_INSTR;
        count_left_next = 7'd0;
        column_next     = '0;
      end else begin
        phase_next      = phase_step;
        count_left_next = count_step;
        column_next     = col_step;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_INSTR;
      count_left <= 7'd0;
      column     <= '0;
    end else begin
      phase      <= phase_next;
      count_left <= count_left_next;
      column     <= column_next;
    end
  end

  // Result queue: up to two writes, one read per cycle.
  assign push_n = accept ? ({1'b0, pix_valid} + {1'b0, codes.scanline_end}) : 2'd0;
  assign count_next = count + {{(CNT_W-2){1'b0}}, push_n} - {{(CNT_W-1){1'b0}}, pop};

  always_ff @(posedge clk) begin
    if (accept) begin
      if (pix_valid) begin
        queue[wr_ptr] <= pix_rec;
        if (codes.scanline_end) begin
          queue[wr_ptr + PTR_W'(1)] <= stat_rec;
        end
      end else if (codes.scanline_end) begin
        queue[wr_ptr] <= stat_rec;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(push_n);
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      count <= count_next;
    end
  end

  assign codes.ready          = (count <= CNT_ROOM2);
  assign records.valid        = (count != '0);
  assign records.record_kind  = queue[rd_ptr].kind;
  assign records.pixel_value  = queue[rd_ptr].value;
  assign records.run_length   = queue[rd_ptr].len;
  assign records.start_column = queue[rd_ptr].col;
  assign records.last_of_run  = queue[rd_ptr].last;

  `RSD_ASSERT(a_queue_bound, count <= CNT_FULL, "result queue overflow")
  `RSD_ASSERT(a_line_restart, accept && codes.scanline_end |=> phase == PH_INSTR && column == '0, "parser not restarted after line end")
  `RSD_ASSERT(a_lit_pending, phase == PH_LIT |-> count_left != 7'd0, "literal phase with no bytes due")
  `RSD_ASSERT_ALWAYS(a_reset_empty, rst |=> count == '0 && !records.valid, "queue not empty after reset")

endmodule

### tb/sv/rle_scanline_decoder_tb.sv
module rle_scanline_decoder_tb;
  import rsd_pkg::*;

  localparam logic [7:0] STOP_CODE    = 8'h00;
  localparam logic [7:0] LITERAL_FLAG = 8'h80;
  localparam int unsigned QUIET_LIMIT  = 5000;
  localparam int unsigned DRAIN_CYCLES = 4;

  typedef enum logic [1:0] {
    AWAIT_INSTR,
    AWAIT_VALUE,
    IN_LITERAL,
    STOPPED
  } parse_phase_t;

  logic               clk = 1'b0;
  logic               rst;
  logic               cfg_wr_en;
  logic [WIDTH_W-1:0] cfg_wr_data;

  rsd_code_if   codes ();
  rsd_record_if records ();

  rle_scanline_decoder dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .codes       (codes),
    .records     (records)
  );

  always #5 clk = ~clk;

  // decoder copy kept in step with accepted bytes
  parse_phase_t       parse_phase;
  logic [6:0]         bytes_due;
  logic [COL_W-1:0]   next_column;
  logic [WIDTH_W-1:0] line_width;

  record_t     expected_records[$];
  logic [7:0]  line_buf[$];

  int unsigned src_idle_pct;
  int unsigned sink_stall_pct;
  int unsigned bytes_sent;
  int unsigned records_checked;
  int unsigned mismatches;
  int unsigned lines_complete;
  int unsigned lines_mismatch;
  int unsigned lines_truncated;
  int unsigned quiet_cycles;

  task automatic predict_records(input logic [7:0] b, input logic fin);
    record_t      pix;
    record_t      status;
    logic         has_pix;
    logic [COL_W:0] sum;
    kind_t        k;
    has_pix = 1'b0;
    pix = '0;
    case (parse_phase)
      AWAIT_INSTR: begin
        if (b == STOP_CODE) begin
          parse_phase = STOPPED;
        end else begin
          bytes_due = b[6:0];
          if (!b[7]) parse_phase = AWAIT_VALUE;
          else if (bytes_due != 0) parse_phase = IN_LITERAL;
        end
      end
      AWAIT_VALUE, IN_LITERAL: begin
        has_pix   = 1'b1;
        pix.kind  = KIND_RUN;
        pix.value = b;
        pix.len   = (parse_phase == AWAIT_VALUE) ? bytes_due : 7'd1;
        pix.col   = next_column;
        pix.last  = !fin;
        sum = {1'b0, next_column} + pix.len;
        next_column = (sum > COL_MAX) ? COL_MAX : sum[COL_W-1:0];
        bytes_due = bytes_due - pix.len;
        if (bytes_due == 0) parse_phase = AWAIT_INSTR;
      end
      default: ;
    endcase
    if (has_pix) expected_records.push_back(pix);
    if (fin) begin
      if (parse_phase == AWAIT_VALUE || parse_phase == IN_LITERAL) k = KIND_TRUNC;
      else if (next_column == {1'b0, line_width}) k = KIND_COMPLETE;
      else k = KIND_MISMATCH;
      status.kind  = k;
      status.value = 8'd0;
      status.len   = 7'd0;
      status.col   = next_column;
      status.last  = 1'b1;
      expected_records.push_back(status);
      parse_phase = AWAIT_INSTR;
      bytes_due   = 7'd0;
      next_column = '0;
    end
  endtask

  task automatic send_code(input logic [7:0] b, input logic fin);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      codes.valid = 1'b0;
      codes.code_byte = 8'($urandom);
      @(negedge clk);
    end
    // hold the request until the decoder takes it
    codes.valid = 1'b1;
    codes.code_byte = b;
    codes.scanline_end = fin;
    @(posedge clk);
    while (!codes.ready) @(posedge clk);
    predict_records(b, fin);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_line_buf();
    for (int i = 0; i < line_buf.size(); i++)
      send_code(line_buf[i], i == line_buf.size() - 1);
    codes.valid = 1'b0;
  endtask

  task automatic wait_drained();
    codes.valid = 1'b0;
    while (expected_records.size() != 0) @(negedge clk);
    // instruction-only bytes may still be in flight
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_width(input logic [WIDTH_W-1:0] w);
    wait_drained();
    cfg_wr_en   = 1'b1;
    cfg_wr_data = w;
    @(negedge clk);
    cfg_wr_en   = 1'b0;
    cfg_wr_data = 16'($urandom);
    line_width  = w;
  endtask

  task automatic add_run(input int unsigned n, input logic [7:0] v);
    line_buf.push_back({1'b0, 7'(n)});
    line_buf.push_back(v);
  endtask

  task automatic add_literal(input int unsigned n);
    line_buf.push_back(LITERAL_FLAG | 8'(n));
    repeat (n) line_buf.push_back(8'($urandom));
  endtask

  task automatic build_random_line(input int unsigned target);
    int unsigned roll;
    int unsigned left;
    int unsigned n;
    int unsigned k;
    line_buf.delete();
    roll = $urandom_range(0, 99);
    if (roll < 55) begin
      // well-formed line landing exactly on the width
      left = target;
      while (left != 0) begin
        if ($urandom_range(0, 9) == 0) line_buf.push_back(LITERAL_FLAG);
        if ($urandom_range(0, 99) < 60) begin
          n = $urandom_range(1, (left < 127) ? left : 127);
          add_run(n, 8'($urandom));
        end else begin
          n = $urandom_range(1, (left < 6) ? left : 6);
          add_literal(n);
        end
        left -= n;
      end
    end else if (roll < 90) begin
      k = $urandom_range(1, 4);
      repeat (k) begin
        if ($urandom_range(0, 1)) add_run($urandom_range(1, 127), 8'($urandom));
        else if ($urandom_range(0, 99) < 5) add_literal($urandom_range(7, 127));
        else add_literal($urandom_range(0, 6));
      end
      if (roll >= 75) begin
        // cut short: value or literal bytes still due at the flag
        if ($urandom_range(0, 1)) begin
          line_buf.push_back({1'b0, 7'($urandom_range(1, 127))});
        end else begin
          n = $urandom_range(2, 8);
          line_buf.push_back(LITERAL_FLAG | 8'(n));
          repeat ($urandom_range(0, n - 1)) line_buf.push_back(8'($urandom));
        end
      end
    end else begin
      repeat ($urandom_range(1, 6)) line_buf.push_back(8'($urandom));
    end
    if (roll < 75 && $urandom_range(0, 1)) begin
      line_buf.push_back(STOP_CODE);
      repeat ($urandom_range(0, 3)) line_buf.push_back(8'($urandom));
    end
    if (line_buf.size() == 0) line_buf.push_back(STOP_CODE);
  endtask

  task automatic flag_mismatch(input string what, input record_t want, input record_t seen);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%s: want kind=%0d value=%02h len=%0d col=%0d last=%0b",
               what, want.kind, want.value, want.len, want.col, want.last);
      $display("  got kind=%0d value=%02h len=%0d col=%0d last=%0b",
               seen.kind, seen.value, seen.len, seen.col, seen.last);
    end
  endtask

  always @(negedge clk) records.ready = ($urandom_range(0, 99) >= sink_stall_pct);

  always @(posedge clk) begin : check_records
    record_t seen;
    record_t want;
    if (!rst && records.valid && records.ready) begin
      seen.kind  = kind_t'(records.record_kind);
      seen.value = records.pixel_value;
      seen.len   = records.run_length;
      seen.col   = records.start_column;
      seen.last  = records.last_of_run;
      if (expected_records.size() == 0) begin
        flag_mismatch("unexpected record", '0, seen);
      end else begin
        want = expected_records.pop_front();
        records_checked++;
        case (want.kind)
          KIND_COMPLETE: lines_complete++;
          KIND_MISMATCH: lines_mismatch++;
          KIND_TRUNC:    lines_truncated++;
          default: ;
        endcase
        if (seen !== want) flag_mismatch("record mismatch", want, seen);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (codes.valid && codes.ready) || (records.valid && records.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("timeout: no request moved for %0d cycles", QUIET_LIMIT);
        $display("FAIL rle_scanline_decoder");
        $finish;
      end
    end
  end

  // width stays at its reset value of 1
  task automatic test_reset_width();
    line_buf = '{8'h01, 8'hFF, STOP_CODE};
    send_line_buf();
  endtask

  task automatic test_directed_codes();
    set_width(16'd6);
    // empty literal, run, literal, flag on a literal byte -> pixel then status
    line_buf = '{LITERAL_FLAG, 8'h02, 8'h00, 8'h83, 8'h11, 8'h22, 8'h33, 8'h81, 8'hA5};
    send_line_buf();
    // bytes after the stop are ignored
    line_buf = '{8'h7F, 8'h5A, STOP_CODE, 8'hFF, LITERAL_FLAG, 8'h01};
    send_line_buf();
    // truncated inside a run and inside a literal
    line_buf = '{8'h05};
    send_line_buf();
    line_buf = '{8'h82, 8'h10};
    send_line_buf();
    set_width(16'd0);
    line_buf = '{STOP_CODE};
    send_line_buf();
    line_buf = '{LITERAL_FLAG};
    send_line_buf();
    line_buf = '{8'h01, 8'h07};
    send_line_buf();
  endtask

  task automatic test_random(input int unsigned src_pct, input int unsigned sink_pct,
                             input int unsigned items);
    int unsigned start;
    set_width(16'($urandom_range(1, 300)));
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
    start = bytes_sent;
    while (bytes_sent - start < items) begin
      build_random_line(line_width);
      send_line_buf();
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    codes.valid = 1'b0;
    codes.code_byte = '0;
    codes.scanline_end = 1'b0;
    records.ready = 1'b0;
    src_idle_pct = 0;
    sink_stall_pct = 0;
    bytes_sent = 0;
    records_checked = 0;
    mismatches = 0;
    lines_complete = 0;
    lines_mismatch = 0;
    lines_truncated = 0;
    quiet_cycles = 0;
    parse_phase = AWAIT_INSTR;
    bytes_due = '0;
    next_column = '0;
    line_width = WIDTH_RESET;
    repeat (7) @(negedge clk);
    rst = 1'b0;

    test_reset_width();
    test_directed_codes();
    test_random(0, 0, 105);
    test_random(51, 0, 105);
    test_random(0, 51, 105);
    test_random(25, 25, 105);

    wait_drained();
    repeat (10) @(negedge clk);
    if (expected_records.size() != 0) begin
      $display("%0d expected records never arrived", expected_records.size());
      mismatches += expected_records.size();
    end
    $display("Sent %0d bytes, checked %0d records: %0d complete, %0d mismatch, %0d truncated",
             bytes_sent, records_checked, lines_complete, lines_mismatch, lines_truncated);
    $display("Widths 0, 1, 6 and random; idle/stall mixes; %0d mismatches", mismatches);
    if (mismatches == 0) begin
      $display("PASS rle_scanline_decoder");
    end else begin
      $display("FAIL rle_scanline_decoder");
    end
    $finish;
  end

endmodule
